@@ rtl/hpdw_pkg.sv @@
package hpdw_pkg;

  // Field widths.
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned CoefWidth   = 15;
  localparam int unsigned ProdWidth   = 2 * SampleWidth;
  localparam int unsigned SumWidth    = SampleWidth + 3;

  // Configuration register indexes.
  typedef enum logic {
    REG_FEEDBACK_COEF = 1'b0,
    REG_INPUT_GAIN    = 1'b1
  } cfg_reg_e;

  // Register reset values: Q15(0.8360692637) and Q15(0.91803463198).
  localparam logic [CoefWidth-1:0] FeedbackCoefReset = 15'd27395;
  localparam logic [CoefWidth-1:0] InputGainReset    = 15'd30081;

  // The filter runs when the knob is above half scale.
  localparam logic [CoefWidth-1:0] KnobHalf = 15'h3FFF;
  localparam logic [CoefWidth-1:0] Q15One   = 15'd32767;

  localparam logic signed [SumWidth-1:0] SatMax = 19'sd32767;
  localparam logic signed [SumWidth-1:0] SatMin = -19'sd32768;

  // Clamp a wide signed value to the Q15 sample range.
  function automatic logic signed [SampleWidth-1:0] sat_q15(
    input logic signed [SumWidth-1:0] v
  );
    logic signed [SampleWidth-1:0] r;
    if (v > SatMax) begin
      r = 16'sh7FFF;
    end else if (v < SatMin) begin
      r = 16'sh8000;
    end else begin
      r = v[SampleWidth-1:0];
    end
    return r;
  endfunction

  // Q15 product: full product shifted right by 15, floor rounding.
  function automatic logic signed [SumWidth-1:0] q15_shift(
    input logic signed [ProdWidth-1:0] p
  );
    logic signed [ProdWidth-1:0] s;
    s = p >>> 15;
    return s[SumWidth-1:0];
  endfunction

endpackage

@@ rtl/highpass_dry_wet_mixer.sv @@
// One-pole high-pass filter with dry/wet mix on Q15 audio samples.
//
// Input channel (in_valid_i / in_ready_o) carries one sample with its wet
// level and effect knob; output channel (out_valid_o / out_ready_i) carries
// one processed sample per input transaction, in order.
// All multiplications share a single 16x16 signed multiplier, stepped by a
// small sequencer, so one transaction is worked on at a time. With the knob
// at or below half scale the result is the gain-scaled sample; with the
// filter active it takes six steps (gain, feedback, filter sum, wet product,
// dry product, mix). The next input is taken once the sequencer is back in
// idle.
// The result sits in an output register; the block accepts the next input
// while it waits. If the receiver stalls and the output register is still
// full when a new result is done, the sequencer holds in its last step.
// Reset clears the filter history and loads the default feedback coefficient
// and input gain. The configuration port writes the register cfg_idx_i selects
// and is to be used only while the block is idle; the block does not enforce it.
module highpass_dry_wet_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] sample_in_i,
  input  logic [14:0] wet_level_i,
  input  logic [14:0] effect_knob_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] sample_out_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StGain = 3'd1;
  localparam logic [2:0] StFb   = 3'd2;
  localparam logic [2:0] StFilt = 3'd3;
  localparam logic [2:0] StWet  = 3'd4;
  localparam logic [2:0] StDry  = 3'd5;
  localparam logic [2:0] StMix  = 3'd6;

  logic [2:0] state_q, state_d;

  logic [14:0] alpha_q, gain_q;
  logic signed [15:0] x_q;
  logic [14:0] wet_q;
  logic active_q;
  logic signed [15:0] scaled_q, y_q, wet_part_q;
  logic signed [15:0] prev_x_q, prev_y_q;
  logic signed [31:0] prod_q;
  logic out_valid_q;
  logic signed [15:0] out_q;

  logic signed [15:0] mul_a;
  logic [14:0] mul_b;
  logic signed [31:0] prod_d;
  logic signed [15:0] prod_q15;
  logic signed [15:0] filt_y;
  logic signed [15:0] mix_y;
  logic out_free;
  logic in_fire;

  assign in_ready_o   = (state_q == StIdle);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= hpdw_pkg::FeedbackCoefReset;
      gain_q  <= hpdw_pkg::InputGainReset;
    end else if (cfg_we_i) begin
      unique case (hpdw_pkg::cfg_reg_e'(cfg_idx_i))
        hpdw_pkg::REG_FEEDBACK_COEF: alpha_q <= cfg_data_i;
        hpdw_pkg::REG_INPUT_GAIN:    gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_q)
      StGain: begin
        mul_a = x_q;
        mul_b = gain_q;
      end
      StFb: begin
        mul_a = prev_y_q;
        mul_b = alpha_q;
      end
      StWet: begin
        mul_a = y_q;
        mul_b = wet_q;
      end
      StDry: begin
        mul_a = scaled_q;
        mul_b = hpdw_pkg::Q15One - wet_q;
      end
      default: begin
        mul_a = x_q;
        mul_b = gain_q;
      end
    endcase
  end

  assign prod_d   = mul_a * $signed({1'b0, mul_b});
  assign prod_q15 = hpdw_pkg::sat_q15(hpdw_pkg::q15_shift(prod_q));

  // Filter sum: scaled - previous scaled + alpha * previous output.
  assign filt_y = hpdw_pkg::sat_q15(
    19'(scaled_q) - 19'(prev_x_q) + hpdw_pkg::q15_shift(prod_q));

  // Mix sum: wet part plus dry part.
  assign mix_y = hpdw_pkg::sat_q15(19'(wet_part_q) + 19'(prod_q15));

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_fire) state_d = StGain;
      StGain: state_d = StFb;
      StFb: begin
        if (active_q) begin
          state_d = StFilt;
        end else if (out_free) begin
          state_d = StIdle;
        end
      end
      StFilt: state_d = StWet;
      StWet:  state_d = StDry;
      StDry:  state_d = StMix;
      StMix:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Filter history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else if (state_q == StFilt) begin
      prev_x_q <= scaled_q;
      prev_y_q <= filt_y;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q      <= sample_in_i;
      wet_q    <= wet_level_i;
      active_q <= (effect_knob_i > hpdw_pkg::KnobHalf);
    end
    // Hold the product while stalled in a final step.
    if (state_q != StFb && state_q != StMix) begin
      prod_q <= prod_d;
    end else if (state_q == StFb && active_q) begin
      prod_q <= prod_d;
    end
    if (state_q == StFb) begin
      scaled_q <= prod_q15;
    end
    if (state_q == StFilt) begin
      y_q <= filt_y;
    end
    if (state_q == StDry) begin
      wet_part_q <= prod_q15;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= ((state_q == StFb) && !active_q) || (state_q == StMix);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (state_q == StFb) begin
        out_q <= prod_q15;
      end else if (state_q == StMix) begin
        out_q <= mix_y;
      end
    end
  end

endmodule
